FILE: sv/cmr_pkg.sv
// Shared types and constants of the color map resampler.
package cmr_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_NUM_STEPS  = 1'b0;
    localparam logic CFG_NUM_POINTS = 1'b1;

    localparam logic [1:0] RD_SEL_IDX  = 2'd0;
    localparam logic [1:0] RD_SEL_IDX1 = 2'd1;
    localparam logic [1:0] RD_SEL_LAST = 2'd2;

    localparam int POS_W   = 17;
    localparam int CHAN_W  = 16;
    localparam int COLOR_W = 4 * CHAN_W;
    localparam int MEM_W   = POS_W + COLOR_W;
    localparam int CFG_W   = 9;

    localparam int DIV_NW = 36;
    localparam int DIV_DW = 17;

    localparam logic [POS_W-1:0] Q16_ONE = 17'h10000;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         point_index;
        logic [POS_W-1:0]   position;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
        logic [CHAN_W-1:0]  alpha_in;
        logic [7:0]         step_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         step_out;
        logic [POS_W-1:0]   sample_position;
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
        logic [CHAN_W-1:0]  alpha_out;
    } out_item_t;

    typedef struct packed {
        logic       accept;
        logic       srch_clr;
        logic       srch_step;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       div_x_start;
        logic       div_c_start;
        logic       cap_x;
        logic       cap_lo;
        logic       cap_hi;
        logic       prep;
        logic       cap_last;
        logic       mul0;
        logic       mul1;
        logic       cap_chan;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic is_last;
        logic div_busy;
        logic srch_more;
        logic pos_le_x;
        logic chan_direct;
        logic chan_last;
        logic out_busy;
    } status_t;

endpackage

FILE: sv/cmr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/cmr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module cmr_div
    import cmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              busy,
    output logic [DIV_NW-1:0] quot
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quot_reg, quot_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[DIV_NW-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CW'(DIV_NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIV_NW-2:0], ge};
            rem_next  = ge ? DIV_DW'(rem_sh - {1'b0, den_reg}) : DIV_DW'(rem_sh);
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

FILE: sv/cmr_datapath.sv
// Datapath: point memory, configuration, search index, multiplier, divider, output register.
module cmr_datapath
    import cmr_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_STEPS  = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  in_item_t         in_data,
    input  logic             out_stall,
    output logic             out_valid,
    output out_item_t        out_data,
    input  cmd_t             cmd,
    output status_t          status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_STEPS);

    logic [CFG_W-1:0] num_steps_reg, num_points_reg;
    logic [7:0]       step_reg;
    logic [POS_W-1:0] x_reg;
    logic [AW-1:0]    idx_reg;
    logic [POS_W-1:0] lo_pos_reg, hi_pos_reg;
    logic [COLOR_W-1:0] lo_color_reg, hi_color_reg, res_color_reg;
    logic signed [17:0] w_reg, t_reg;
    logic signed [19:0] wmt_reg;
    logic               w_zero_reg;
    logic signed [36:0] prod_reg;
    logic signed [37:0] num_reg;
    logic [1:0]         chan_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [31:0] steps_c, n_c, step_c;
    logic [SW-1:0] last;
    logic [AW-1:0] n_m1;
    logic [AW-1:0] rd_addr;
    logic [MEM_W-1:0] rd_data;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [POS_W-1:0] rd_pos;
    logic signed [17:0] w_raw, t_raw;
    logic [CHAN_W-1:0] c0, c1, chan_val;
    logic [DIV_NW-1:0] div_num, quot;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;

    always_comb
    begin
        steps_c = 32'(num_steps_reg);
        if (steps_c < 32'd2)
        begin
            steps_c = 32'd2;
        end
        else if (steps_c > 32'(MAX_STEPS))
        begin
            steps_c = 32'(MAX_STEPS);
        end
        n_c = 32'(num_points_reg);
        if (n_c < 32'd2)
        begin
            n_c = 32'd2;
        end
        else if (n_c > 32'(MAX_POINTS))
        begin
            n_c = 32'(MAX_POINTS);
        end
        last   = SW'(steps_c - 32'd1);
        n_m1   = AW'(n_c - 32'd1);
        step_c = 32'(in_data.step_index);
        if (step_c > 32'(last))
        begin
            step_c = 32'(last);
        end
    end

    // Point memory: position above the four channels, red in the low bits.
    assign mem_we  = cmd.accept && (in_data.opcode == OP_LOAD)
                     && (32'(in_data.point_index) < 32'(MAX_POINTS));
    assign wr_addr = AW'(32'(in_data.point_index));

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_SEL_IDX:  rd_addr = idx_reg;
            RD_SEL_IDX1: rd_addr = AW'(idx_reg + 1'b1);
            RD_SEL_LAST: rd_addr = n_m1;
            default:     rd_addr = idx_reg;
        endcase
    end

    cmr_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data ({in_data.position, in_data.alpha_in, in_data.blue_in,
                   in_data.green_in, in_data.red_in}),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_pos = rd_data[MEM_W-1 -: POS_W];

    assign div_num = cmd.div_c_start ? DIV_NW'(num_reg) : DIV_NW'({step_reg, 16'h0000});
    assign div_den = cmd.div_c_start ? DIV_DW'(w_reg) : DIV_DW'(last);

    cmr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_x_start || cmd.div_c_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign w_raw = $signed({1'b0, hi_pos_reg}) - $signed({1'b0, lo_pos_reg});
    assign t_raw = $signed({1'b0, x_reg}) - $signed({1'b0, lo_pos_reg});
    assign c0    = lo_color_reg[chan_reg*CHAN_W +: CHAN_W];
    assign c1    = hi_color_reg[chan_reg*CHAN_W +: CHAN_W];

    always_comb
    begin
        if (w_zero_reg)
        begin
            chan_val = c1;
        end
        else if (num_reg <= 38'sd0)
        begin
            chan_val = '0;
        end
        else if (|quot[DIV_NW-1:CHAN_W])
        begin
            chan_val = '1;
        end
        else
        begin
            chan_val = quot[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_steps_reg  <= 9'd256;
            num_points_reg <= 9'd2;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            chan_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_STEPS:  num_steps_reg  <= cfg_data;
                    CFG_NUM_POINTS: num_points_reg <= cfg_data;
                    default:        num_steps_reg  <= num_steps_reg;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.srch_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.srch_step)
            begin
                idx_reg <= AW'(idx_reg + 1'b1);
            end
            if (cmd.cap_hi)
            begin
                chan_reg <= '0;
            end
            else if (cmd.cap_chan)
            begin
                chan_reg <= chan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            step_reg <= 8'(step_c);
        end
        if (cmd.cap_x)
        begin
            x_reg <= POS_W'(quot);
        end
        if (cmd.cap_lo)
        begin
            lo_pos_reg   <= rd_pos;
            lo_color_reg <= rd_data[COLOR_W-1:0];
        end
        if (cmd.cap_hi)
        begin
            hi_pos_reg   <= rd_pos;
            hi_color_reg <= rd_data[COLOR_W-1:0];
        end
        if (cmd.prep)
        begin
            // A falling segment is mirrored so that the width is positive.
            w_reg      <= w_raw[17] ? -w_raw : w_raw;
            t_reg      <= w_raw[17] ? -t_raw : t_raw;
            wmt_reg    <= w_raw[17] ? (20'(t_raw) - 20'(w_raw)) : (20'(w_raw) - 20'(t_raw));
            w_zero_reg <= (w_raw == 18'sd0);
        end
        if (cmd.mul0)
        begin
            prod_reg <= $signed({1'b0, c0}) * wmt_reg;
        end
        if (cmd.mul1)
        begin
            num_reg <= 38'(prod_reg) + 38'($signed({1'b0, c1}) * t_reg);
        end
        if (cmd.cap_chan)
        begin
            res_color_reg[chan_reg*CHAN_W +: CHAN_W] <= chan_val;
        end
        if (cmd.cap_last)
        begin
            res_color_reg <= rd_data[COLOR_W-1:0];
            x_reg         <= Q16_ONE;
        end
        if (cmd.out_load)
        begin
            out_data_reg.step_out        <= step_reg;
            out_data_reg.sample_position <= x_reg;
            out_data_reg.red_out         <= res_color_reg[0*CHAN_W +: CHAN_W];
            out_data_reg.green_out       <= res_color_reg[1*CHAN_W +: CHAN_W];
            out_data_reg.blue_out        <= res_color_reg[2*CHAN_W +: CHAN_W];
            out_data_reg.alpha_out       <= res_color_reg[3*CHAN_W +: CHAN_W];
        end
    end

    assign status.is_query    = (in_data.opcode == OP_QUERY);
    assign status.is_last     = (32'(step_reg) == 32'(last));
    assign status.div_busy    = div_busy;
    assign status.srch_more   = ((AW+1)'(idx_reg) + 1'b1) < (AW+1)'(n_m1);
    assign status.pos_le_x    = (rd_pos <= x_reg);
    assign status.chan_direct = w_zero_reg || (num_reg <= 38'sd0);
    assign status.chan_last   = (chan_reg == 2'd3);
    assign status.out_busy    = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/cmr_ctrl.sv
// Controller state machine sequencing loads, the segment search and interpolation.
module cmr_ctrl
    import cmr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_QUERY     = 4'd1;
    localparam logic [3:0] S_DIVX_WAIT = 4'd2;
    localparam logic [3:0] S_SRCH_RD   = 4'd3;
    localparam logic [3:0] S_SRCH_CMP  = 4'd4;
    localparam logic [3:0] S_RD_LO     = 4'd5;
    localparam logic [3:0] S_RD_HI     = 4'd6;
    localparam logic [3:0] S_RD_WAIT   = 4'd7;
    localparam logic [3:0] S_PREP      = 4'd8;
    localparam logic [3:0] S_MUL0      = 4'd9;
    localparam logic [3:0] S_MUL1      = 4'd10;
    localparam logic [3:0] S_CH_DEC    = 4'd11;
    localparam logic [3:0] S_CH_DIV    = 4'd12;
    localparam logic [3:0] S_LAST_RD   = 4'd13;
    localparam logic [3:0] S_LAST_CAP  = 4'd14;
    localparam logic [3:0] S_OUT       = 4'd15;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_query)
                    begin
                        state_next = S_QUERY;
                    end
                end
            end
            S_QUERY:
            begin
                if (status.is_last)
                begin
                    state_next = S_LAST_RD;
                end
                else
                begin
                    cmd.div_x_start = 1'b1;
                    state_next      = S_DIVX_WAIT;
                end
            end
            S_DIVX_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.cap_x    = 1'b1;
                    cmd.srch_clr = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (status.srch_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SEL_IDX1;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_RD_LO;
                end
            end
            S_SRCH_CMP:
            begin
                if (status.pos_le_x)
                begin
                    cmd.srch_step = 1'b1;
                    state_next    = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_IDX;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.cap_lo = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_IDX1;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_CH_DEC;
            end
            S_CH_DEC:
            begin
                if (status.chan_direct)
                begin
                    cmd.cap_chan = 1'b1;
                    state_next   = status.chan_last ? S_OUT : S_MUL0;
                end
                else
                begin
                    cmd.div_c_start = 1'b1;
                    state_next      = S_CH_DIV;
                end
            end
            S_CH_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.cap_chan = 1'b1;
                    state_next   = status.chan_last ? S_OUT : S_MUL0;
                end
            end
            S_LAST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_LAST;
                state_next = S_LAST_CAP;
            end
            S_LAST_CAP:
            begin
                cmd.cap_last = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: sv/color_map_resampler_top.sv
// Top level of the color map resampler: controller, datapath and ports.
// Load requests give no result. A query for the last step reads the last point
// and needs no division; any other query uses the shared divider once for the
// position and once for each channel that is not set directly, and searches the
// points one after another.
// Reset clears the controller, output valid and configuration (256 steps, 2
// points); the point memory is not cleared and holds garbage until loaded.
module color_map_resampler_top
    import cmr_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_STEPS  = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    // The controller only sees status flags and drives commands; all data,
    // including the point memory and the divider, lives in the datapath.
    cmd_t    cmd;
    status_t status;

    cmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The output register lets a new request be accepted while the previous
    // result still waits on a stalled output.
    cmr_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_STEPS  (MAX_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: test/color_map_resampler_checker.sv
// Checker for the color map resampler: predicts table entries and compares them.
`timescale 1ns / 1ps

module color_map_resampler_checker
    import cmr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  out_item_t        out_data,
    output int               fail_count,
    output int               pending
);

    logic [POS_W-1:0]  map_pos [0:255];
    logic [CHAN_W-1:0] map_chan [0:255][0:3];
    logic [CFG_W-1:0]  steps_reg;
    logic [CFG_W-1:0]  points_reg;
    out_item_t         entry_q[$];

    function automatic int clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] blend(input longint c0, input longint c1,
                                                input longint w, input longint t);
        longint num;
        longint q;
        if (w == 0)
            return c1[CHAN_W-1:0];
        if (w < 0)
        begin
            w = -w;
            t = -t;
        end
        num = c0 * (w - t) + c1 * t;
        if (num <= 0)
            return '0;
        q = num / w;
        if (q > 65535)
            q = 65535;
        return q[CHAN_W-1:0];
    endfunction

    function automatic out_item_t table_entry(input logic [7:0] step_req);
        out_item_t e;
        int steps;
        int n;
        int last;
        int i;
        int seg;
        longint x;
        logic [CHAN_W-1:0] ch [0:3];
        steps = clamp_cfg(steps_reg, 256);
        n = clamp_cfg(points_reg, 256);
        last = steps - 1;
        i = (step_req > last) ? last : step_req;
        if (i == last)
        begin
            for (int k = 0; k < 4; k++)
                ch[k] = map_chan[n-1][k];
            x = 65536;
        end
        else
        begin
            x = (longint'(i) * 65536) / last;
            seg = 0;
            while (seg < n - 2 && map_pos[seg+1] <= x)
                seg++;
            for (int k = 0; k < 4; k++)
                ch[k] = blend(map_chan[seg][k], map_chan[seg+1][k],
                              longint'(map_pos[seg+1]) - longint'(map_pos[seg]),
                              x - longint'(map_pos[seg]));
        end
        e.step_out = i[7:0];
        e.sample_position = x[POS_W-1:0];
        e.red_out = ch[0];
        e.green_out = ch[1];
        e.blue_out = ch[2];
        e.alpha_out = ch[3];
        return e;
    endfunction

    assign pending = entry_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= 9'd256;
            points_reg <= 9'd2;
            fail_count <= 0;
            entry_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_NUM_STEPS)
                    steps_reg <= cfg_data;
                else
                    points_reg <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.opcode == OP_LOAD)
                begin
                    map_pos[in_data.point_index] = in_data.position;
                    map_chan[in_data.point_index][0] = in_data.red_in;
                    map_chan[in_data.point_index][1] = in_data.green_in;
                    map_chan[in_data.point_index][2] = in_data.blue_in;
                    map_chan[in_data.point_index][3] = in_data.alpha_in;
                end
                else
                    entry_q.push_back(table_entry(in_data.step_index));
            end
            if (out_valid && !out_stall)
            begin
                if (entry_q.size() == 0)
                begin
                    $display("%0t: unexpected entry %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else if (entry_q[0] !== out_data)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             entry_q[0], out_data);
                    fail_count <= fail_count + 1;
                    void'(entry_q.pop_front());
                end
                else
                    void'(entry_q.pop_front());
            end
        end
    end

endmodule

FILE: test/color_map_resampler_top_tb.sv
// Testbench top for the color map resampler: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module color_map_resampler_top_tb;
    import cmr_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    int               fail_count;
    int               pending;

    // Idling switches; clearing them gives stretches of full throughput.
    bit send_gaps;
    bit sink_gaps;
    int requests_sent;

    color_map_resampler_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    color_map_resampler_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls on about one cycle in five while gaps are enabled.
    always @(posedge clk)
        out_stall <= sink_gaps && ($urandom_range(99) < 19);

    // Sends one request. Called in the time step of a rising edge; returns in the
    // time step of the edge at which the request was accepted, with valid still
    // high so that the next request can follow without a bubble.
    task automatic send_request(input in_item_t req);
        while (send_gaps && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    // Drops valid and waits until every table entry has come back, then lets the
    // block finish any trailing load before the configuration may change.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t load_req(input logic [7:0] slot, input logic [POS_W-1:0] pos);
        in_item_t r;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(in_item_t)-1:0];
        r.opcode = OP_LOAD;
        r.point_index = slot;
        r.position = pos;
        return r;
    endfunction

    function automatic in_item_t query_req(input logic [7:0] step);
        in_item_t r;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(in_item_t)-1:0];
        r.opcode = OP_QUERY;
        r.step_index = step;
        return r;
    endfunction

    // Loads points 0..n-1. Modes: 0 sorted spread, 1 fully random order,
    // 2 sorted with repeated positions so zero-width segments appear.
    task automatic load_map(input int n, input int mode);
        int pos;
        pos = $urandom_range(0, 8000);
        for (int k = 0; k < n; k++)
        begin
            if (mode == 1)
                pos = $urandom_range(0, 65536);
            else if (k > 0 && !(mode == 2 && $urandom_range(1) == 0))
                pos = pos + $urandom_range(0, 2 * 65536 / n);
            if (pos > 65536)
                pos = 65536;
            send_request(load_req(k[7:0], pos[POS_W-1:0]));
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] steps_val;
        logic [CFG_W-1:0] points_val;
        int n;
        int steps;
        int phase;
        in_item_t r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_NUM_STEPS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration of 256 steps and 2 points.
        send_request(load_req(8'd0, 17'd0));
        r = load_req(8'd1, Q16_ONE);
        r.red_in = 16'hFFFF;
        r.green_in = 16'h0000;
        r.blue_in = 16'hFFFF;
        r.alpha_in = 16'h0000;
        send_request(r);
        send_request(load_req(8'd255, 17'd12345));
        send_request(query_req(8'd0));
        send_request(query_req(8'd128));
        send_request(query_req(8'd254));
        send_request(query_req(8'd255));
        // A zero-width segment takes the upper color.
        send_request(load_req(8'd1, 17'd0));
        send_request(query_req(8'd0));
        send_request(query_req(8'd77));
        // A descending segment has negative width; points past it extrapolate.
        send_request(load_req(8'd0, Q16_ONE));
        send_request(load_req(8'd1, 17'd30000));
        send_request(query_req(8'd10));
        send_request(query_req(8'd200));
        drain();

        // Out-of-range register values saturate; a step beyond the table clamps.
        write_reg(CFG_NUM_STEPS, 9'd0);
        write_reg(CFG_NUM_POINTS, 9'd1);
        send_request(query_req(8'd0));
        send_request(query_req(8'd1));
        send_request(query_req(8'd255));
        drain();
        write_reg(CFG_NUM_STEPS, 9'd511);
        write_reg(CFG_NUM_POINTS, 9'd3);
        send_request(load_req(8'd2, Q16_ONE));
        send_request(query_req(8'd100));
        send_request(query_req(8'd255));
        drain();

        // Random phases: each sets a configuration, loads a full map and then
        // mixes queries with reloads of points.
        phase = 0;
        while (requests_sent < 1700)
        begin
            case (phase % 8)
                0: points_val = 9'd2;
                1: points_val = (phase == 9) ? 9'd256 : 9'd4;
                2: points_val = (phase == 18) ? 9'd300 : 9'd3;
                default: points_val = CFG_W'($urandom_range(2, 12));
            endcase
            case ($urandom_range(5))
                0: steps_val = 9'd2;
                1: steps_val = 9'd256;
                2: steps_val = CFG_W'($urandom_range(257, 511));
                3: steps_val = CFG_W'($urandom_range(0, 1));
                default: steps_val = CFG_W'($urandom_range(3, 255));
            endcase
            write_reg(CFG_NUM_STEPS, steps_val);
            write_reg(CFG_NUM_POINTS, points_val);
            n = (points_val < 2) ? 2 : (points_val > 256) ? 256 : int'(points_val);
            steps = (steps_val < 2) ? 2 : (steps_val > 256) ? 256 : int'(steps_val);
            send_gaps = (phase % 5) != 3;
            sink_gaps = (phase % 5) != 3;
            load_map(n, $urandom_range(0, 5) / 2);
            for (int j = 0; j < ((n > 16) ? 12 : 40); j++)
            begin
                if ($urandom_range(99) < 20)
                    send_request(load_req(8'($urandom_range(0, n - 1)),
                                          POS_W'($urandom_range(0, 65536))));
                else if ($urandom_range(99) < 15)
                    send_request(query_req(8'($urandom_range(0, 255))));
                else
                    send_request(query_req(8'($urandom_range(0, steps - 1))));
            end
            drain();
            phase++;
        end

        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
